### src/tes_pkg.sv
package tes_pkg;

    localparam int TAG_BITS  = 16;
    localparam int INFO_BITS = TAG_BITS + 3;

    localparam logic [31:0] TPB_RESET = 32'd95109;

    // Request codes
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_SCHEDULE = 3'd1;
    localparam logic [2:0] REQ_REMOVE   = 3'd2;
    localparam logic [2:0] REQ_MOVE     = 3'd3;
    localparam logic [2:0] REQ_REWIND   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // Result kinds
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  slot_id;
        logic [15:0] client_tag;
        logic [39:0] delay_ticks;
        logic        repeat_flag;
        logic [1:0]  delivery_class;
        logic [63:0] new_time;
    } t_req;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  status;
        logic [4:0]  out_slot;
        logic [15:0] fired_client;
        logic [1:0]  fired_class;
        logic [63:0] fired_target;
        logic        last_result;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SC_FIND,
        S_FI_CHK,
        S_FI_W1,
        S_FI_W2,
        S_FI_CMP,
        S_UF_CHK,
        S_UF_CMP,
        S_SD_CHK,
        S_SD_W,
        S_SD_WR,
        S_UNLINKED,
        S_IS_CHK,
        S_IS_W,
        S_IS_CMP,
        S_SU_CHK,
        S_SU_W,
        S_SU_WR,
        S_INSERTED,
        S_ACK,
        S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_ADV,
        OP_REWIND,
        OP_IDX_CLR,
        OP_IDX_INC,
        OP_IDX_DEC,
        OP_SD_WR,
        OP_SU_WR,
        OP_LINK,
        OP_CNT_DEC,
        OP_SET_POS,
        OP_SLOT_LD,
        OP_FIRE,
        OP_FREE,
        OP_REARM,
        OP_SLOT_INC,
        OP_ALLOC,
        OP_MV_SET,
        OP_RM_LD,
        OP_ACK_SLOT,
        OP_ACK_FULL,
        OP_ACK_BAD,
        OP_ACK_ZERO,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        logic [2:0] req_type;
        logic       idx_eq_cnt;
        logic       idx1_ge_cnt;
        logic       idx_eq_pos;
        logic       cnt_zero;
        logic       cnt_full;
        logic       cap_hit;
        logic       due;
        logic       earlier;
        logic       ord_match;
        logic       slot_free;
        logic       sid_bad;
        logic       rep;
    } t_stat;

endpackage

### src/tes_datapath.sv
module tes_datapath import tes_pkg::*; #(
    parameter int EVENT_SLOTS = 32,
    parameter int FIRE_LIMIT  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output t_stat       o_stat,
    output logic        o_res_strobe,
    output t_res        o_res
);

    localparam int SW       = $clog2(EVENT_SLOTS);
    localparam int CW       = $clog2(EVENT_SLOTS + 1);
    localparam int FIRE_CAP = (FIRE_LIMIT < 16) ? FIRE_LIMIT : 16;
    localparam int FW       = $clog2(FIRE_CAP + 1);

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // Slot store and ordered list
    logic [SW-1:0]        m_order  [EVENT_SLOTS];
    logic [63:0]          m_target [EVENT_SLOTS];
    logic [39:0]          m_delay  [EVENT_SLOTS];
    logic [INFO_BITS-1:0] m_info   [EVENT_SLOTS];

    logic [31:0]          r_tpb;
    logic [63:0]          r_now;
    logic [CW-1:0]        r_count;
    logic [EVENT_SLOTS-1:0] r_used;
    logic [FW-1:0]        r_fires;
    logic                 r_pend_v;
    logic                 r_strobe;

    t_req                 r_req;
    logic [SW-1:0]        r_slot;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_pos;
    logic [63:0]          r_key;
    logic                 r_rep;
    logic [SW-1:0]        r_ord_q;
    logic [63:0]          r_tgt_q;
    logic [39:0]          r_dly_q;
    logic [INFO_BITS-1:0] r_info_q;
    t_res                 r_pend;
    t_res                 r_res;

    logic [SW-1:0]        w_sid;
    logic                 w_sid_big;
    logic [63:0]          w_sched_tgt;
    logic [CW-1:0]        w_idx_m1;
    logic [CW-1:0]        w_idx_p1;
    logic                 w_ord_we;
    logic [CW-1:0]        w_ord_wa;
    logic [SW-1:0]        w_ord_wd;
    logic                 w_push;
    t_res                 w_new;

    assign w_sid       = SW'(r_req.slot_id);
    assign w_sid_big   = ({27'd0, r_req.slot_id} >= 32'(EVENT_SLOTS));
    assign w_sched_tgt = sat_add(r_now, {24'd0, r_req.delay_ticks});
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_idx_p1    = r_idx + CW'(1);

    // Status back to the controller
    always_comb begin
        o_stat.req_type    = r_req.req_type;
        o_stat.idx_eq_cnt  = (r_idx == r_count);
        o_stat.idx1_ge_cnt = ({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_count};
        o_stat.idx_eq_pos  = (r_idx == r_pos);
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.cnt_full    = (r_count == CW'(EVENT_SLOTS));
        o_stat.cap_hit     = (r_fires == FW'(FIRE_CAP));
        o_stat.due         = (r_tgt_q < r_now);
        o_stat.earlier     = (r_tgt_q < r_key);
        o_stat.ord_match   = (r_ord_q == r_slot);
        o_stat.slot_free   = !r_used[r_slot];
        o_stat.sid_bad     = w_sid_big || !r_used[w_sid];
        o_stat.rep         = r_rep;
    end

    // Order list write port
    always_comb begin
        w_ord_we = 1'b0;
        w_ord_wa = r_idx;
        w_ord_wd = r_ord_q;
        unique case (i_op)
            OP_SD_WR: begin
                w_ord_we = 1'b1;
                w_ord_wa = w_idx_m1;
            end
            OP_SU_WR: begin
                w_ord_we = 1'b1;
                w_ord_wa = w_idx_p1;
            end
            OP_LINK: begin
                w_ord_we = 1'b1;
                w_ord_wa = r_pos;
                w_ord_wd = r_slot;
            end
            default: w_ord_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ord_q <= m_order[r_idx[SW-1:0]];
        if (w_ord_we) begin
            m_order[w_ord_wa[SW-1:0]] <= w_ord_wd;
        end
    end

    // Slot store: read at the list head or scan entry, write at the working slot
    always_ff @(posedge i_clk) begin
        r_tgt_q  <= m_target[r_ord_q];
        r_dly_q  <= m_delay[r_ord_q];
        r_info_q <= m_info[r_ord_q];
        if (i_op == OP_ALLOC) begin
            m_target[r_slot] <= w_sched_tgt;
            m_delay[r_slot]  <= r_req.delay_ticks;
            m_info[r_slot]   <= {r_req.delivery_class, r_req.repeat_flag,
                                 r_req.client_tag[TAG_BITS-1:0]};
        end else if (i_op == OP_REARM) begin
            m_target[r_slot] <= r_key;
        end else if (i_op == OP_MV_SET) begin
            m_target[r_slot] <= r_req.new_time;
        end
    end

    // Result for this cycle, if any
    always_comb begin
        w_push = 1'b1;
        w_new  = '0;
        unique case (i_op)
            OP_FIRE: begin
                w_new.result_kind  = KIND_FIRE;
                w_new.status       = ST_OK;
                w_new.out_slot     = 5'(r_slot);
                w_new.fired_client = 16'(r_info_q[TAG_BITS-1:0]);
                w_new.fired_class  = r_info_q[TAG_BITS+2:TAG_BITS+1];
                w_new.fired_target = r_tgt_q;
            end
            OP_ACK_SLOT: begin
                w_new.status   = ST_OK;
                w_new.out_slot = 5'(r_slot);
            end
            OP_ACK_FULL: w_new.status = ST_FULL;
            OP_ACK_BAD: begin
                w_new.status   = ST_BAD;
                w_new.out_slot = r_req.slot_id;
            end
            OP_ACK_ZERO, OP_REWIND: w_new.status = ST_OK;
            default: w_push = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb    <= TPB_RESET;
            r_now    <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_fires  <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tpb <= i_cfg_wdata;
            end
            // Release the held beat when a newer one arrives or at the end
            r_strobe <= r_pend_v && (w_push || (i_op == OP_FLUSH));
            unique case (i_op)
                OP_ADV: begin
                    r_now   <= r_now + {32'd0, r_tpb};
                    r_fires <= '0;
                end
                OP_REWIND:  r_now <= '0;
                OP_LINK:    r_count <= r_count + CW'(1);
                OP_CNT_DEC: r_count <= r_count - CW'(1);
                OP_FIRE:    r_fires <= r_fires + FW'(1);
                OP_FREE:    r_used[r_slot] <= 1'b0;
                OP_ALLOC:   r_used[r_slot] <= 1'b1;
                default: ;
            endcase
            // Hold one result back so the last beat can be marked
            if (w_push) begin
                r_pend_v <= 1'b1;
            end else if (i_op == OP_FLUSH) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pend <= w_new;
            r_res  <= {r_pend[$bits(t_res)-1:1], 1'b0};
        end else if (i_op == OP_FLUSH) begin
            r_res <= {r_pend[$bits(t_res)-1:1], 1'b1};
        end
        unique case (i_op)
            OP_LATCH: begin
                r_req  <= i_req;
                r_slot <= '0;
                r_idx  <= '0;
            end
            OP_IDX_CLR:  r_idx <= '0;
            OP_IDX_INC:  r_idx <= w_idx_p1;
            OP_IDX_DEC:  r_idx <= w_idx_m1;
            OP_SET_POS: begin
                r_pos <= r_idx;
                r_idx <= r_count;
            end
            OP_SLOT_LD:  r_slot <= r_ord_q;
            OP_FIRE: begin
                r_key <= sat_add(r_tgt_q, {24'd0, r_dly_q});
                r_rep <= r_info_q[TAG_BITS];
            end
            OP_REARM:    r_idx <= '0;
            OP_SLOT_INC: r_slot <= r_slot + SW'(1);
            OP_ALLOC: begin
                r_key <= w_sched_tgt;
                r_idx <= '0;
            end
            OP_MV_SET: begin
                r_key <= r_req.new_time;
                r_idx <= '0;
            end
            OP_RM_LD: begin
                r_slot <= w_sid;
                r_idx  <= '0;
            end
            default: ;
        endcase
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

### src/tes_ctrl.sv
module tes_ctrl import tes_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (i_stat.req_type)
                    REQ_TICK:     n_state = S_FI_CHK;
                    REQ_SCHEDULE: n_state = i_stat.cnt_full ? S_DONE : S_SC_FIND;
                    REQ_REMOVE, REQ_MOVE: n_state = i_stat.sid_bad ? S_DONE : S_UF_CHK;
                    default:      n_state = S_DONE;
                endcase
            end
            S_SC_FIND:  if (i_stat.slot_free) n_state = S_IS_CHK;
            S_FI_CHK:   n_state = (i_stat.cap_hit || i_stat.cnt_zero) ? S_DONE : S_FI_W1;
            S_FI_W1:    n_state = S_FI_W2;
            S_FI_W2:    n_state = S_FI_CMP;
            S_FI_CMP:   n_state = i_stat.due ? S_SD_CHK : S_DONE;
            S_UF_CHK:   n_state = i_stat.idx_eq_cnt ? S_ACK : S_UF_CMP;
            S_UF_CMP:   n_state = i_stat.ord_match ? S_SD_CHK : S_UF_CHK;
            S_SD_CHK:   n_state = i_stat.idx1_ge_cnt ? S_UNLINKED : S_SD_W;
            S_SD_W:     n_state = S_SD_WR;
            S_SD_WR:    n_state = S_SD_CHK;
            S_UNLINKED: begin
                unique case (i_stat.req_type)
                    REQ_TICK:   n_state = i_stat.rep ? S_IS_CHK : S_FI_CHK;
                    REQ_MOVE:   n_state = S_IS_CHK;
                    default:    n_state = S_ACK;
                endcase
            end
            S_IS_CHK:   n_state = i_stat.idx_eq_cnt ? S_SU_CHK : S_IS_W;
            S_IS_W:     n_state = S_IS_CMP;
            S_IS_CMP:   n_state = i_stat.earlier ? S_IS_CHK : S_SU_CHK;
            S_SU_CHK:   n_state = i_stat.idx_eq_pos ? S_INSERTED : S_SU_W;
            S_SU_W:     n_state = S_SU_WR;
            S_SU_WR:    n_state = S_SU_CHK;
            S_INSERTED: n_state = (i_stat.req_type == REQ_TICK) ? S_FI_CHK : S_ACK;
            S_ACK:      n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath command
    always_comb begin
        o_op = OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_start) o_op = OP_LATCH;
            S_DISPATCH: begin
                unique case (i_stat.req_type)
                    REQ_TICK:     o_op = OP_ADV;
                    REQ_SCHEDULE: o_op = i_stat.cnt_full ? OP_ACK_FULL : OP_NONE;
                    REQ_REMOVE, REQ_MOVE: o_op = i_stat.sid_bad ? OP_ACK_BAD : OP_RM_LD;
                    REQ_REWIND:   o_op = OP_REWIND;
                    default:      o_op = OP_ACK_ZERO;
                endcase
            end
            S_SC_FIND:  o_op = i_stat.slot_free ? OP_ALLOC : OP_SLOT_INC;
            S_FI_CHK:   o_op = (i_stat.cap_hit || i_stat.cnt_zero) ? OP_NONE : OP_IDX_CLR;
            S_FI_W2:    o_op = OP_SLOT_LD;
            S_FI_CMP:   o_op = i_stat.due ? OP_FIRE : OP_NONE;
            S_UF_CMP:   o_op = i_stat.ord_match ? OP_NONE : OP_IDX_INC;
            S_SD_CHK:   o_op = i_stat.idx1_ge_cnt ? OP_CNT_DEC : OP_IDX_INC;
            S_SD_WR:    o_op = OP_SD_WR;
            S_UNLINKED: begin
                unique case (i_stat.req_type)
                    REQ_TICK:   o_op = i_stat.rep ? OP_REARM : OP_FREE;
                    REQ_MOVE:   o_op = OP_MV_SET;
                    default:    o_op = OP_FREE;
                endcase
            end
            S_IS_CHK:   o_op = i_stat.idx_eq_cnt ? OP_SET_POS : OP_NONE;
            S_IS_CMP:   o_op = i_stat.earlier ? OP_IDX_INC : OP_SET_POS;
            S_SU_CHK:   o_op = i_stat.idx_eq_pos ? OP_LINK : OP_IDX_DEC;
            S_SU_WR:    o_op = OP_SU_WR;
            S_ACK:      o_op = OP_ACK_SLOT;
            S_DONE:     o_op = OP_FLUSH;
            default:    o_op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/timed_event_scheduler_top.sv
// A tick unlinks each event that it fires and re-inserts a repeating one, scanning the
//   list for its place and shifting later entries. Schedule, remove and move skip used
//   slots or walk list entries. One request at a time; the last result beat is on the
//   ports in the first cycle with busy low. Results cannot be stalled.
// Reset clears time, slot-used bits and the list count; tick length returns to 95109.
module timed_event_scheduler_top import tes_pkg::*; #(
    parameter int EVENT_SLOTS = 32,
    parameter int FIRE_LIMIT  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_res_strobe,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    t_op   w_op;
    t_stat w_stat;

    tes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_busy  (busy)
    );

    tes_datapath #(
        .EVENT_SLOTS (EVENT_SLOTS),
        .FIRE_LIMIT  (FIRE_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_stat       (w_stat),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

### src/tes_checker.sv
module tes_checker import tes_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_strobe,
    input t_res        o_res
);

    // Results only follow a cycle in which a request was in work
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy)) else $error("result beat while idle");

    // An accepted request holds busy in the next cycle
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    // Nothing follows the last beat of a request
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last_result) |=> !o_res_strobe)
        else $error("beat after last result");

    // An acknowledge is always the only and final beat
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.result_kind == KIND_ACK)) |-> o_res.last_result)
        else $error("acknowledge not marked last");

endmodule

bind timed_event_scheduler_top tes_checker u_chk (.*);

### tb/sv/tb_timed_event_scheduler_top.sv
`timescale 1ns / 100ps

module tb_timed_event_scheduler_top;
    import tes_pkg::*;

    localparam int SLOTS = 32;
    localparam int FIRE_CAP = 16;
    localparam logic [2:0] REQ_RSVD5 = 3'd5;
    localparam logic [2:0] REQ_RSVD6 = 3'd6;
    localparam logic [2:0] REQ_RSVD7 = 3'd7;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_res_strobe;
    t_res        o_res;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    // Scheduler mirror
    logic [31:0] sch_tpb;
    logic [63:0] sch_now;
    logic [63:0] sch_target [SLOTS];
    logic [39:0] sch_delay [SLOTS];
    logic [15:0] sch_tag [SLOTS];
    logic        sch_rep [SLOTS];
    logic [1:0]  sch_cls [SLOTS];
    bit          sch_used [SLOTS];
    int          sch_order [$];

    t_res beats_due [$];
    int   err_count = 0;
    bit   quiet = 1'b0;
    t_row dir_rows [$];

    timed_event_scheduler_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #100000000;
        $display("tb_timed_event_scheduler_top NOT OK");
        $finish;
    end

    function automatic t_req mk_req(logic [2:0] rt, logic [4:0] sid, logic [15:0] tag,
                                    logic [39:0] dly, logic rep, logic [1:0] cls,
                                    logic [63:0] nt);
        t_req r;
        r.req_type = rt;
        r.slot_id = sid;
        r.client_tag = tag;
        r.delay_ticks = dly;
        r.repeat_flag = rep;
        r.delivery_class = cls;
        r.new_time = nt;
        return r;
    endfunction

    function automatic t_res mk_res(logic kind, logic [1:0] st, logic [4:0] slot,
                                    logic [15:0] cl, logic [1:0] cls, logic [63:0] tgt,
                                    logic last);
        t_res r;
        r.result_kind = kind;
        r.status = st;
        r.out_slot = slot;
        r.fired_client = cl;
        r.fired_class = cls;
        r.fired_target = tgt;
        r.last_result = last;
        return r;
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Place a slot before any entries with an equal or later target
    function automatic void link_slot(int s);
        int p;
        p = 0;
        while (p < sch_order.size() && sch_target[sch_order[p]] < sch_target[s])
            p++;
        sch_order.insert(p, s);
    endfunction

    function automatic void unlink(int s);
        foreach (sch_order[i])
            if (sch_order[i] == s) begin
                sch_order.delete(i);
                return;
            end
    endfunction

    // Advance the mirror by one accepted request and queue its result beats
    function automatic void schedule_step(t_req r);
        int n0;
        int s;
        int k;
        logic [63:0] t;
        n0 = beats_due.size();
        case (r.req_type)
            REQ_TICK: begin
                sch_now = sch_now + {32'd0, sch_tpb};
                k = 0;
                while (k < FIRE_CAP && sch_order.size() > 0) begin
                    s = sch_order[0];
                    t = sch_target[s];
                    if (!(t < sch_now))
                        break;
                    beats_due.push_back(mk_res(KIND_FIRE, ST_OK, s[4:0], sch_tag[s],
                                               sch_cls[s], t, 1'b0));
                    k++;
                    void'(sch_order.pop_front());
                    if (sch_rep[s]) begin
                        sch_target[s] = sat_sum(t, {24'd0, sch_delay[s]});
                        link_slot(s);
                    end else begin
                        sch_used[s] = 1'b0;
                    end
                end
            end
            REQ_SCHEDULE: begin
                s = 0;
                while (s < SLOTS && sch_used[s])
                    s++;
                if (sch_order.size() >= SLOTS || s >= SLOTS) begin
                    beats_due.push_back(mk_res(KIND_ACK, ST_FULL, '0, '0, '0, '0, 1'b0));
                end else begin
                    sch_used[s] = 1'b1;
                    sch_delay[s] = r.delay_ticks;
                    sch_target[s] = sat_sum(sch_now, {24'd0, r.delay_ticks});
                    sch_tag[s] = r.client_tag;
                    sch_rep[s] = r.repeat_flag;
                    sch_cls[s] = r.delivery_class;
                    link_slot(s);
                    beats_due.push_back(mk_res(KIND_ACK, ST_OK, s[4:0], '0, '0, '0, 1'b0));
                end
            end
            REQ_REMOVE, REQ_MOVE: begin
                s = r.slot_id;
                if (!sch_used[s]) begin
                    beats_due.push_back(mk_res(KIND_ACK, ST_BAD, r.slot_id, '0, '0, '0, 1'b0));
                end else begin
                    unlink(s);
                    if (r.req_type == REQ_REMOVE) begin
                        sch_used[s] = 1'b0;
                    end else begin
                        sch_target[s] = r.new_time;
                        link_slot(s);
                    end
                    beats_due.push_back(mk_res(KIND_ACK, ST_OK, r.slot_id, '0, '0, '0, 1'b0));
                end
            end
            REQ_REWIND: begin
                sch_now = '0;
                beats_due.push_back(mk_res(KIND_ACK, ST_OK, '0, '0, '0, '0, 1'b0));
            end
            default: begin
                beats_due.push_back(mk_res(KIND_ACK, ST_OK, '0, '0, '0, '0, 1'b0));
            end
        endcase
        if (beats_due.size() > n0)
            beats_due[beats_due.size() - 1].last_result = 1'b1;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Check every result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (beats_due.size() == 0) begin
                report("unexpected beat", o_res.fired_target, '0);
            end else begin
                want = beats_due.pop_front();
                if (o_res.result_kind !== want.result_kind)
                    report("result_kind", 64'(o_res.result_kind), 64'(want.result_kind));
                if (o_res.status !== want.status)
                    report("status", 64'(o_res.status), 64'(want.status));
                if (o_res.out_slot !== want.out_slot)
                    report("out_slot", 64'(o_res.out_slot), 64'(want.out_slot));
                if (o_res.fired_client !== want.fired_client)
                    report("fired_client", 64'(o_res.fired_client), 64'(want.fired_client));
                if (o_res.fired_class !== want.fired_class)
                    report("fired_class", 64'(o_res.fired_class), 64'(want.fired_class));
                if (o_res.fired_target !== want.fired_target)
                    report("fired_target", o_res.fired_target, want.fired_target);
                if (o_res.last_result !== want.last_result)
                    report("last_result", 64'(o_res.last_result), 64'(want.last_result));
            end
        end
    end

    // Drop start for a random burst now and then
    task automatic idle_burst();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            @(negedge i_clk) start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // Hold one request until the block takes it
    task automatic send(t_req r, bit typed, t_res res);
        int n0;
        idle_burst();
        @(negedge i_clk) begin
            start <= 1'b1;
            i_req <= r;
        end
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        n0 = beats_due.size();
        schedule_step(r);
        if (typed) begin
            if (beats_due.size() != n0 + 1)
                report("typed row beat count", 64'(beats_due.size() - n0), 64'd1);
            else
                beats_due[n0] = res;
        end
    endtask

    // Wait until every beat is in and the block has gone quiet
    task automatic drain();
        @(negedge i_clk) start <= 1'b0;
        while (beats_due.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_tpb(logic [31:0] v);
        drain();
        @(negedge i_clk) begin
            i_cfg_we <= 1'b1;
            i_cfg_wdata <= v;
        end
        @(negedge i_clk) i_cfg_we <= 1'b0;
        sch_tpb = v;
    endtask

    function automatic t_req rand_req();
        t_req r;
        int pick;
        logic [63:0] span;
        r = t_req'(131'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 36)
            r.req_type = REQ_TICK;
        else if (pick < 66)
            r.req_type = REQ_SCHEDULE;
        else if (pick < 78)
            r.req_type = REQ_REMOVE;
        else if (pick < 91)
            r.req_type = REQ_MOVE;
        else if (pick < 95)
            r.req_type = REQ_REWIND;
        else
            r.req_type = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
        // Mostly address a live slot
        if (sch_order.size() > 0 && $urandom_range(0, 3) != 0)
            r.slot_id = 5'(sch_order[$urandom_range(0, sch_order.size() - 1)]);
        span = 64'd3 * {32'd0, sch_tpb} + 64'd1;
        case ($urandom_range(0, 9))
            0: r.delay_ticks = '0;
            1: ;
            default: r.delay_ticks = 40'({$urandom, $urandom} % span);
        endcase
        // Zero-delay repeats flood every tick, so keep them rare
        if (r.delay_ticks == 0 && $urandom_range(0, 2) != 0)
            r.repeat_flag = 1'b0;
        if ($urandom_range(0, 3) != 0)
            r.new_time = sch_now + ({$urandom, $urandom} % span);
        return r;
    endfunction

    task automatic run_random(int count);
        t_res none;
        none = '0;
        repeat (count) send(rand_req(), 1'b0, none);
    endtask

    initial begin
        t_res none;
        t_req r;
        none = '0;
        sch_tpb = TPB_RESET;
        sch_now = '0;
        foreach (sch_used[i]) begin
            sch_used[i] = 1'b0;
            sch_target[i] = '0;
            sch_delay[i] = '0;
            sch_tag[i] = '0;
            sch_rep[i] = 1'b0;
            sch_cls[i] = '0;
        end

        // Directed rows: typed results only where they are obvious
        dir_rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_REMOVE, 5, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_BAD, 5, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_MOVE, 31, 0, 0, 0, 0, '1), 1,
                             mk_res(KIND_ACK, ST_BAD, 31, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_REWIND, 0, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_RSVD5, 31, '1, '1, 1, 3, '1), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_RSVD6, 0, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_RSVD7, 3, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_SCHEDULE, 0, 16'hFFFF, 0, 0, 3, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_SCHEDULE, 0, 0, '1, 1, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_SCHEDULE, 0, 16'h1234, 40'd95108, 1, 1, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_SCHEDULE, 0, 16'h5678, 40'd95108, 1, 2, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_SCHEDULE, 0, 16'hA5A5, 0, 1, 1, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_REMOVE, 3, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 3, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_MOVE, 1, 0, 0, 0, 0, '1), 1,
                             mk_res(KIND_ACK, ST_OK, 1, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_MOVE, 2, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_OK, 2, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_TICK, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_REMOVE, 3, 0, 0, 0, 0, 0), 1,
                             mk_res(KIND_ACK, ST_BAD, 3, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(REQ_REMOVE, 0, 0, 0, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk_req(REQ_REWIND, 0, 0, 0, 0, 0, 0), 0, none});

        // Reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        // Fill the table past full with events far in the future
        write_tpb(32'd1);
        repeat (34) begin
            r = rand_req();
            r.req_type = REQ_SCHEDULE;
            r.delay_ticks = 40'd1000 + 40'($urandom_range(0, 5000));
            send(r, 1'b0, none);
        end
        run_random(5);

        // Largest step drains most of the table
        write_tpb(32'hFFFF_FFFF);
        run_random(15);

        write_tpb(TPB_RESET);
        run_random(10);
        drain();
        run_random(10);

        // Close with no idle gaps
        write_tpb($urandom_range(1, 32'h0010_0000));
        quiet = 1'b1;
        run_random(15);

        drain();
        if (err_count == 0)
            $display("tb_timed_event_scheduler_top OK");
        else
            $display("tb_timed_event_scheduler_top NOT OK");
        $finish;
    end

endmodule
